// ===== src/linear_probe_hash_table_defines.svh =====
// assertion macros shared by the hash table rtl
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising edge outside reset
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg)
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/lpht_pkg.sv =====
// types and constants of the linear probing hash table
`default_nettype none

package lpht_pkg;

  // key width
  localparam int KEY_W = 31;

  typedef enum logic [1:0] {
    OP_INSERT        = 2'd0,
    OP_INSERT_UNIQUE = 2'd1,
    OP_SEARCH        = 2'd2,
    OP_DELETE        = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_DELETED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [KEY_W-1:0]   key;
  } in_item_t;

  typedef struct packed {
    status_t      status;
    logic [3:0]   slot_index;
    logic [4:0]   comparisons;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/linear_probe_hash_table.sv =====
// top level: probe sequencer of the linear probing hash table
//
// Open-addressing table of nonzero 31-bit keys with linear probing over SLOTS
// slots held in one synchronous memory. After reset the block first clears
// the memory, one slot per cycle; in_stall is high meanwhile. One item is
// worked on at a time: the home slot unit reduces the key modulo SLOTS by a
// multiplication with the reciprocal and one correcting subtract, then one
// memory read is made per probed slot (1 to SLOTS slots, or none for a zero
// key), and the result is handed to the output register once that is free
// before the block returns to idle. A finished result waits in the output
// register while the next item is already being taken.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  opcode_t            op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               home_done;
  logic [IW-1:0]      home;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [KEY_W-1:0]   mem_rdata;

  logic [IW-1:0]      idx_inc;
  logic [CW-1:0]      cnt_inc;
  logic               hit;
  logic               empty;
  logic               last;
  logic               is_insert;

  assign in_xfer = in_valid && !in_stall;

  lpht_home #(
    .SLOTS(SLOTS)
  ) u_home (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_xfer),
    .key  (in_data.key),
    .done (home_done),
    .home (home)
  );

  lpht_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // probe step helpers
  assign idx_inc   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;
  assign hit       = (mem_rdata == key_r);
  assign empty     = (mem_rdata == '0);
  assign last      = (cnt_r == LAST_CNT);
  assign is_insert = (op_r == OP_INSERT) || (op_r == OP_INSERT_UNIQUE);

  // read ahead: the next slot is read while the current one is checked
  assign mem_raddr = (state_r == S_PROBE) ? idx_inc : home;

  // sequencer: clear, hash, probe, hand over
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = key_r;
    in_stall      = 1'b1;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          key_nxt   = in_data.key;
          state_nxt = S_HASH;
        end
      end

      S_HASH: begin
        if (home_done) begin
          idx_nxt = home;
          cnt_nxt = '0;
          if (key_r == '0) begin
            // zero key is never stored
            res_nxt.status      = is_insert ? ST_FULL : ST_ABSENT;
            res_nxt.slot_index  = '0;
            res_nxt.comparisons = '0;
            state_nxt           = S_DONE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        res_nxt.slot_index  = '0;
        res_nxt.comparisons = '0;
        if (is_insert) begin
          if ((op_r == OP_INSERT_UNIQUE) && hit) begin
            res_nxt.status = ST_DUPLICATE;
            state_nxt      = S_DONE;
          end else if (empty) begin
            mem_we             = 1'b1;
            res_nxt.status     = ST_INSERTED;
            res_nxt.slot_index = 4'(idx_r);
            state_nxt          = S_DONE;
          end else if (last) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_inc;
          end
        end else begin
          if (hit) begin
            if (op_r == OP_DELETE) begin
              mem_we         = 1'b1;
              mem_wdata      = '0;
              res_nxt.status = ST_DELETED;
            end else begin
              res_nxt.status = ST_FOUND;
            end
            res_nxt.slot_index  = 4'(idx_r);
            res_nxt.comparisons = 5'(cnt_inc);
            state_nxt           = S_DONE;
          end else if (empty) begin
            res_nxt.status      = ST_ABSENT;
            res_nxt.comparisons = 5'(cnt_r);
            state_nxt           = S_DONE;
          end else if (last) begin
            // full lap without the key
            res_nxt.status      = ST_ABSENT;
            res_nxt.comparisons = 5'(cnt_inc);
            state_nxt           = S_DONE;
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_inc;
          end
        end
      end

      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LPHT_ASSERT_NXT(a_write_ends_probe, mem_we && (state_r == S_PROBE), state_r == S_DONE, "memory write did not end the probe")
  `LPHT_ASSERT_IMP(a_probe_bound, state_r == S_PROBE, cnt_r < CW'(SLOTS), "probe ran past a full lap")
  `LPHT_ASSERT_IMP(a_home_in_hash, home_done, state_r == S_HASH, "home slot ready outside hash state")
  `LPHT_ASSERT_IMP(a_slot_zero, out_valid_r && (out_data_r.status == ST_DUPLICATE || out_data_r.status == ST_FULL || out_data_r.status == ST_ABSENT), out_data_r.slot_index == 4'd0, "slot index set for a result with no slot")
  `LPHT_ASSERT_IMP(a_insert_no_cmp, out_valid_r && (out_data_r.status == ST_INSERTED || out_data_r.status == ST_DUPLICATE || out_data_r.status == ST_FULL), out_data_r.comparisons == 5'd0, "comparison count set for an insert")

endmodule

`default_nettype wire

// ===== src/lpht_home.sv =====
// home slot unit: key modulo slot count by reciprocal multiplication
`default_nettype none

module lpht_home
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [KEY_W-1:0]              key,
  output logic                               done,
  output logic [$clog2(SLOTS)-1:0]           home
);

  localparam int RW = $clog2(SLOTS);
  localparam int PW = 2 * KEY_W;
  localparam logic [RW:0]      SLOTS_W = (RW+1)'(SLOTS);
  // reciprocal of the slot count scaled by 2^KEY_W, rounded down
  localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / SLOTS);

  logic                  mul_vld_r, mul_vld_nxt;
  logic                  done_r, done_nxt;
  logic [RW:0]           q_lo_r, q_lo_nxt;
  logic [RW:0]           key_lo_r, key_lo_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [PW-1:0]         prod;
  logic [RW:0]           part;
  logic [RW:0]           rem_est;

  // quotient estimate: exact or one short for any key below 2^KEY_W
  assign prod = PW'(key) * PW'(RECIP);

  // remainder estimate lies below twice the slot count, so low bits suffice
  assign part    = q_lo_r * SLOTS_W;
  assign rem_est = key_lo_r - part;

  // multiply on start, correct with one compare and subtract in the cycle after
  always_comb begin
    mul_vld_nxt = start;
    done_nxt    = mul_vld_r;
    q_lo_nxt    = q_lo_r;
    key_lo_nxt  = key_lo_r;
    rem_nxt     = rem_r;
    if (start) begin
      q_lo_nxt   = prod[KEY_W +: RW+1];
      key_lo_nxt = key[RW:0];
    end
    if (mul_vld_r) begin
      rem_nxt = (rem_est >= SLOTS_W) ? RW'(rem_est - SLOTS_W) : rem_est[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_lo_r   <= q_lo_nxt;
    key_lo_r <= key_lo_nxt;
    rem_r    <= rem_nxt;
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

`default_nettype wire

// ===== src/lpht_mem.sv =====
// slot memory: one write port, one read port with registered read data
`default_nettype none

module lpht_mem
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(SLOTS)-1:0]   waddr,
  input  wire logic [KEY_W-1:0]           wdata,
  input  wire logic [$clog2(SLOTS)-1:0]   raddr,
  output logic [KEY_W-1:0]                rdata
);

  logic [KEY_W-1:0] mem [SLOTS];
  logic [KEY_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
